// ===== rtl/lwf_pkg.sv =====
// ----------------------------------------------------------------------------
// lwf_pkg: shared types and constants of the LCD window write formatter
// Panel command codes, register indexes, byte slot codes and the job record
// that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package lwf_pkg;

  // largest accepted sprite side
  localparam int unsigned MAX_DIM = 512;

  // panel commands
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  // register reset values
  localparam logic [8:0] PANEL_WIDTH_RST  = 9'd320;
  localparam logic [8:0] PANEL_HEIGHT_RST = 9'd240;

  // job queue
  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);

  typedef enum logic [1:0] {
    REG_PANEL_WIDTH,
    REG_PANEL_HEIGHT,
    REG_COLUMN_OFFSET,
    REG_ROW_OFFSET
  } cfg_reg_t;

  // byte positions within one job: window write, then the two pixel bytes
  typedef enum logic [3:0] {
    SLOT_CASET,
    SLOT_CS_HI,
    SLOT_CS_LO,
    SLOT_CE_HI,
    SLOT_CE_LO,
    SLOT_RASET,
    SLOT_RS_HI,
    SLOT_RS_LO,
    SLOT_RE_HI,
    SLOT_RE_LO,
    SLOT_RAMWR,
    SLOT_PIX_LO,
    SLOT_PIX_HI
  } slot_t;

  typedef struct packed {
    logic [8:0] panel_width;
    logic [8:0] panel_height;
    logic [7:0] column_offset;
    logic [7:0] row_offset;
  } cfg_t;

  typedef struct packed {
    logic        win;     // send a window write first
    logic        pix_en;  // send the pixel
    logic [15:0] cs;
    logic [15:0] ce;
    logic [15:0] rs;
    logic [15:0] re;
    logic [15:0] pix;
  } job_t;

endpackage

// ===== rtl/lwf_front.sv =====
// ----------------------------------------------------------------------------
// lwf_front: sprite tracking and pixel classification
// Takes pixels, keeps sprite geometry and position counters, and turns each
// pixel that produces output into a job record for the back part.
// ----------------------------------------------------------------------------
module lwf_front import lwf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic        first_pixel,
  input  logic [8:0]  pos_x,
  input  logic [8:0]  pos_y,
  input  logic [9:0]  sprite_width,
  input  logic [9:0]  sprite_height,
  input  logic [15:0] pixel,
  input  cfg_t        cfg,
  output job_t        job,
  output logic        job_valid,
  input  logic        job_ready
);

  // sprite state
  logic       latched_mode;
  logic [9:0] latched_width;
  logic [9:0] latched_height;
  logic [9:0] base_col;
  logic [9:0] base_row;
  logic [9:0] col_count;
  logic [9:0] row_count;
  logic       sprite_dropped;

  // classify stage
  logic        s1_valid;
  logic        s1_mode;
  logic [9:0]  s1_width;
  logic [9:0]  s1_height;
  logic [9:0]  s1_base_col;
  logic [9:0]  s1_base_row;
  logic [9:0]  s1_col;
  logic [9:0]  s1_row;
  logic [15:0] s1_pixel;

  logic       eff_mode;
  logic [9:0] eff_width;
  logic [9:0] eff_height;
  logic [9:0] eff_base_col;
  logic [9:0] eff_base_row;
  logic [9:0] eff_col;
  logic [9:0] eff_row;
  logic       new_drop;
  logic       eff_drop;
  logic       item_active;
  logic       col_wrap;
  logic       s1_free;
  logic       accept;

  always_comb begin
    new_drop = (pos_x > cfg.panel_width) || (pos_y > cfg.panel_height) ||
               (sprite_width == '0) || (sprite_height == '0) ||
               (sprite_width > 10'(MAX_DIM)) || (sprite_height > 10'(MAX_DIM));
    eff_mode     = first_pixel ? mode : latched_mode;
    eff_width    = first_pixel ? sprite_width : latched_width;
    eff_height   = first_pixel ? sprite_height : latched_height;
    eff_base_col = first_pixel ? ({1'b0, pos_x} + {2'b0, cfg.column_offset}) : base_col;
    eff_base_row = first_pixel ? ({1'b0, pos_y} + {2'b0, cfg.row_offset}) : base_row;
    eff_col      = first_pixel ? '0 : col_count;
    eff_row      = first_pixel ? '0 : row_count;
    eff_drop     = first_pixel ? new_drop : sprite_dropped;
    item_active  = !eff_drop && (eff_width != '0) && (eff_row < eff_height);
    col_wrap     = ({1'b0, eff_col} + 11'd1) >= {1'b0, eff_width};
  end

  assign s1_free = !s1_valid || !job_valid || job_ready;
  assign full    = !s1_free;
  assign accept  = push && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_mode   <= 1'b0;
      latched_width  <= '0;
      latched_height <= '0;
      base_col       <= '0;
      base_row       <= '0;
      col_count      <= '0;
      row_count      <= '0;
      sprite_dropped <= 1'b0;
      s1_valid       <= 1'b0;
    end else begin
      if (accept) begin
        if (first_pixel) begin
          latched_mode   <= mode;
          latched_width  <= sprite_width;
          latched_height <= sprite_height;
          base_col       <= eff_base_col;
          base_row       <= eff_base_row;
          sprite_dropped <= new_drop;
          col_count      <= '0;
          row_count      <= '0;
        end
        if (item_active) begin
          if (col_wrap) begin
            col_count <= '0;
            row_count <= eff_row + 10'd1;
          end else begin
            col_count <= eff_col + 10'd1;
          end
        end
      end
      if (s1_free) begin
        s1_valid <= accept && item_active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode     <= eff_mode;
      s1_width    <= eff_width;
      s1_height   <= eff_height;
      s1_base_col <= eff_base_col;
      s1_base_row <= eff_base_row;
      s1_col      <= eff_col;
      s1_row      <= eff_row;
      s1_pixel    <= pixel;
    end
  end

  // diamond span of the row: columns shift .. span_end
  logic signed [12:0] shift;
  logic signed [12:0] span_end;
  logic signed [12:0] row2;
  logic signed [12:0] half_w;
  logic signed [12:0] w_s;
  logic signed [12:0] h_s;
  logic signed [12:0] col_s;
  logic               upper;
  logic               in_span;
  logic [15:0]        base16;
  logic [15:0]        row16;

  always_comb begin
    row2   = $signed({2'b0, s1_row, 1'b0});
    half_w = $signed({4'b0, s1_width[9:1]});
    w_s    = $signed({3'b0, s1_width});
    h_s    = $signed({3'b0, s1_height});
    col_s  = $signed({3'b0, s1_col});
    upper  = s1_row < {1'b0, s1_height[9:1]};
    if (upper) begin
      shift    = half_w - row2 - 13'sd2;
      span_end = half_w + row2 + 13'sd1;
    end else begin
      shift    = row2 - h_s;
      span_end = w_s - row2 + h_s - 13'sd1;
    end
    in_span = (col_s >= shift) && (col_s <= span_end);
    base16  = {6'b0, s1_base_col};
    row16   = {6'b0, s1_base_row};

    job.pix = s1_pixel;
    if (!s1_mode) begin
      job.win    = (s1_col == '0) && (s1_row == '0);
      job.pix_en = 1'b1;
      job.cs     = base16;
      job.ce     = base16 + {6'b0, s1_width} - 16'd1;
      job.rs     = row16;
      job.re     = row16 + {6'b0, s1_height} - 16'd1;
    end else begin
      job.win    = (s1_col == '0);
      job.pix_en = in_span;
      job.cs     = base16 + {{3{shift[12]}}, shift};
      job.ce     = base16 + {{3{span_end[12]}}, span_end};
      job.rs     = row16 + {6'b0, s1_row};
      job.re     = row16 + {6'b0, s1_row};
    end
    job_valid = s1_valid && (job.win || job.pix_en);
  end

endmodule

// ===== rtl/lwf_job_fifo.sv =====
// ----------------------------------------------------------------------------
// lwf_job_fifo: short job queue
// First-word-fall-through queue between classification and byte output.
// ----------------------------------------------------------------------------
module lwf_job_fifo import lwf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic ready,
  input  logic rd_en,
  output job_t head,
  output logic valid
);

  job_t                 mem [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr;
  logic [JOB_PTR_W-1:0] rd_ptr;
  logic [JOB_PTR_W:0]   count;
  logic                 do_wr;
  logic                 do_rd;

  assign ready = count != (JOB_PTR_W + 1)'(JOB_DEPTH);
  assign valid = count != '0;
  assign do_wr = wr_en && ready;
  assign do_rd = rd_en && valid;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

endmodule

// ===== rtl/lwf_back.sv =====
// ----------------------------------------------------------------------------
// lwf_back: byte sequencer
// Walks the byte slots of the head job and feeds the output register.
// ----------------------------------------------------------------------------
module lwf_back import lwf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       job,
  input  logic       job_valid,
  output logic       job_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       last
);

  logic       started;
  slot_t      slot;
  slot_t      cur_slot;
  slot_t      end_slot;
  logic       emit_last;
  logic       out_load;
  logic [7:0] emit_byte;
  logic       emit_data;

  always_comb begin
    cur_slot  = started ? slot : (job.win ? SLOT_CASET : SLOT_PIX_LO);
    end_slot  = job.pix_en ? SLOT_PIX_HI : SLOT_RAMWR;
    emit_last = cur_slot == end_slot;
    out_load  = job_valid && (empty || pop);
    job_pop   = out_load && emit_last;
    emit_data = 1'b1;
    case (cur_slot)
      SLOT_CASET:  begin emit_byte = CMD_CASET; emit_data = 1'b0; end
      SLOT_CS_HI:  emit_byte = job.cs[15:8];
      SLOT_CS_LO:  emit_byte = job.cs[7:0];
      SLOT_CE_HI:  emit_byte = job.ce[15:8];
      SLOT_CE_LO:  emit_byte = job.ce[7:0];
      SLOT_RASET:  begin emit_byte = CMD_RASET; emit_data = 1'b0; end
      SLOT_RS_HI:  emit_byte = job.rs[15:8];
      SLOT_RS_LO:  emit_byte = job.rs[7:0];
      SLOT_RE_HI:  emit_byte = job.re[15:8];
      SLOT_RE_LO:  emit_byte = job.re[7:0];
      SLOT_RAMWR:  begin emit_byte = CMD_RAMWR; emit_data = 1'b0; end
      SLOT_PIX_LO: emit_byte = job.pix[7:0];
      SLOT_PIX_HI: emit_byte = job.pix[15:8];
      default:     emit_byte = job.pix[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      slot    <= SLOT_CASET;
      empty   <= 1'b1;
    end else begin
      if (out_load) begin
        started <= !emit_last;
        slot    <= slot_t'(cur_slot + 4'd1);
        empty   <= 1'b0;
      end else if (pop) begin
        empty <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= emit_byte;
      is_data  <= emit_data;
      last     <= emit_last;
    end
  end

`ifndef SYNTHESIS
  // a job under way stays at the queue head
  a_started_has_job: assert property (@(posedge clk) disable iff (rst)
    started |-> job_valid)
    else $error("job left the queue mid-sequence");

  // command bytes are only the three panel commands
  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_data) |->
      (out_byte == CMD_CASET) || (out_byte == CMD_RASET) || (out_byte == CMD_RAMWR))
    else $error("bad command byte");

  // a job retires only on the final byte of its form
  a_retire_slot: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> (cur_slot == SLOT_RAMWR) || (cur_slot == SLOT_PIX_HI))
    else $error("job retired on an inner byte");
`endif

endmodule

// ===== rtl/lcd_window_write_formatter.sv =====
// ----------------------------------------------------------------------------
// lcd_window_write_formatter: sprite pixels to panel byte stream
// Emits CASET/RASET/RAMWR window writes and pixel bytes with the D/C flag,
// for opaque rectangles and isometric diamonds.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  pixel in | push / full                | mode, first_pixel, pos_x, pos_y,
//           |                            | sprite_width, sprite_height, pixel
//  byte out | empty / pop                | out_byte, is_data, last
//  config   | cfg_write (no wait)        | cfg_index, cfg_data
//
//  Output runs at one byte per cycle while a job waits and the sink pops;
//  a plain pixel is 2 bytes, a pixel that opens a window 13, a window with
//  no pixel 11, as set by the byte sequencer.
//  Input takes one pixel per cycle until the 4-entry job queue and the
//  classify register are full.
//  A pixel goes through the classify register, job queue and output register.
//  rst is synchronous; config returns to 320 x 240, offsets 0.
//  Either side may stall; the job queue decouples them.
// ----------------------------------------------------------------------------
module lcd_window_write_formatter import lwf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // pixel input
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic        first_pixel,
  input  logic [8:0]  pos_x,
  input  logic [8:0]  pos_y,
  input  logic [9:0]  sprite_width,
  input  logic [9:0]  sprite_height,
  input  logic [15:0] pixel,
  // byte output
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        is_data,
  output logic        last,
  // register writes
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  // configuration registers; the user must write them only while idle, the block does not enforce it
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.panel_width   <= PANEL_WIDTH_RST;
      cfg.panel_height  <= PANEL_HEIGHT_RST;
      cfg.column_offset <= '0;
      cfg.row_offset    <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PANEL_WIDTH:   cfg.panel_width   <= cfg_data;
        REG_PANEL_HEIGHT:  cfg.panel_height  <= cfg_data;
        REG_COLUMN_OFFSET: cfg.column_offset <= cfg_data[7:0];
        REG_ROW_OFFSET:    cfg.row_offset    <= cfg_data[7:0];
        default:           cfg.row_offset    <= cfg.row_offset;
      endcase
    end
  end

  // front -> queue
  job_t front_job;
  logic front_job_valid;
  logic queue_ready;

  // queue -> back
  job_t head_job;
  logic head_valid;
  logic head_pop;

  // front: tracks sprite position, classifies each pixel into a job
  lwf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .mode          (mode),
    .first_pixel   (first_pixel),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .pixel         (pixel),
    .cfg           (cfg),
    .job           (front_job),
    .job_valid     (front_job_valid),
    .job_ready     (queue_ready)
  );

  // short queue lets a window write drain while pixels keep arriving
  lwf_job_fifo u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (front_job_valid),
    .wr_job (front_job),
    .ready  (queue_ready),
    .rd_en  (head_pop),
    .head   (head_job),
    .valid  (head_valid)
  );

  // back: one byte per cycle into the output register while a job waits and the sink pops
  lwf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_valid (head_valid),
    .job_pop   (head_pop),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .last      (last)
  );

endmodule

// ===== tb/sv/tb_lcd_window_write_formatter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcd_window_write_formatter: self-checking bench of the window formatter
// Sprite pixels go in through push/full and panel bytes come out through
// empty/pop. Every byte is checked against a bench model of the formatter or a
// directed row. The run starts with a directed table and goes on to random
// sprites under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_lcd_window_write_formatter;
  import lwf_pkg::*;

  // run control
  localparam int CYCLE_LIMIT   = 200000; // well above the slowest legal run
  localparam int SETTLE_CYCLES = 32;     // a window write plus pipeline depth
  localparam int PHASE_ITEMS   = 24;     // least pixel transfers per register setting
  localparam int HOLD_AT       = 80;     // transfer count that triggers the long hold
  localparam int LONG_HOLD     = 200;    // cycles the byte sink refuses to pop

  // sprite modes and D/C values
  localparam logic MODE_OPAQUE    = 1'b0;
  localparam logic MODE_ISOMETRIC = 1'b1;
  localparam logic DC_COMMAND     = 1'b0;
  localparam logic DC_DATA        = 1'b1;

  // byte streams that can be read straight off the spec
  // 1x1 opaque sprite at the origin, pixel A55A, reset registers
  localparam logic [0:12][7:0] WIN_ORIGIN_PIX = {
    CMD_CASET, 8'h00, 8'h00, 8'h00, 8'h00,
    CMD_RASET, 8'h00, 8'h00, 8'h00, 8'h00,
    CMD_RAMWR, 8'h5A, 8'hA5};
  // 512x512 opaque sprite at (320, 240), pixel FFFF, reset registers
  localparam logic [0:12][7:0] WIN_CORNER_PIX = {
    CMD_CASET, 8'h01, 8'h40, 8'h03, 8'h3F,
    CMD_RASET, 8'h00, 8'hF0, 8'h02, 8'hEF,
    CMD_RAMWR, 8'hFF, 8'hFF};
  localparam logic [0:12][7:0] PIX_ZERO = '0;
  localparam logic [0:12] DC_WIN_PIX = 13'b0111101111011;
  localparam logic [0:12] DC_PIX     = 13'b1100000000000;

  typedef struct packed {
    logic        mode;
    logic        first_pixel;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [9:0]  sprite_width;
    logic [9:0]  sprite_height;
    logic [15:0] pixel;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } panel_byte_t;

  // directed row; want_n < 0 means the model supplies the bytes
  typedef struct {
    pixel_item_t      it;
    int               want_n;
    logic [0:12][7:0] want;
    logic [0:12]      want_dc;
  } table_row_t;

  // DUT ports
  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        mode;
  logic        first_pixel;
  logic [8:0]  pos_x;
  logic [8:0]  pos_y;
  logic [9:0]  sprite_width;
  logic [9:0]  sprite_height;
  logic [15:0] pixel;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        is_data;
  logic        last;
  logic        cfg_write;
  cfg_reg_t    cfg_index;
  logic [8:0]  cfg_data;

  // register copies held by the model
  logic [8:0] cfg_panel_w;
  logic [8:0] cfg_panel_h;
  logic [7:0] cfg_col_off;
  logic [7:0] cfg_row_off;

  // sprite state held by the model
  logic        spr_mode;
  logic [15:0] spr_base_col;
  logic [15:0] spr_base_row;
  logic [9:0]  spr_w;
  logic [9:0]  spr_h;
  logic [9:0]  spr_col;
  logic [9:0]  spr_row;
  logic        spr_dropped;

  // bytes of the current transfer, then the queue of bytes still owed
  panel_byte_t step_buf [0:12];
  int          step_n;
  panel_byte_t bytes_due [$];
  table_row_t  dir_rows [$];

  // bookkeeping
  int   items_accepted  = 0;
  int   sprites_started = 0;
  int   sprites_dropped = 0;
  int   bytes_seen      = 0;
  int   stall_cycles    = 0;
  int   n_errors        = 0;
  int   cycle_count     = 0;
  logic no_idle         = 1'b0;  // set for the closing phase, read by the sink
  logic long_hold_done  = 1'b0;  // written by the sink only

  lcd_window_write_formatter i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .first_pixel  (first_pixel),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .sprite_width (sprite_width),
    .sprite_height(sprite_height),
    .pixel        (pixel),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .is_data      (is_data),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Model of the formatter
  // --------------------------------------------------------------------------
  function automatic void emit(input logic [7:0] b, input logic dc);
    step_buf[step_n] = {b, dc, 1'b0};
    step_n++;
  endfunction

  // CASET, columns, RASET, rows, RAMWR; coordinates high byte first
  function automatic void emit_window(input logic [15:0] cs, ce, rs, re);
    emit(CMD_CASET, DC_COMMAND);
    emit(cs[15:8], DC_DATA);
    emit(cs[7:0], DC_DATA);
    emit(ce[15:8], DC_DATA);
    emit(ce[7:0], DC_DATA);
    emit(CMD_RASET, DC_COMMAND);
    emit(rs[15:8], DC_DATA);
    emit(rs[7:0], DC_DATA);
    emit(re[15:8], DC_DATA);
    emit(re[7:0], DC_DATA);
    emit(CMD_RAMWR, DC_COMMAND);
  endfunction

  // Bytes that one pixel transfer causes; fills step_buf and step_n.
  function automatic void format_pixel(input pixel_item_t it);
    int          wi, hi, c, r, shift, span;
    logic [15:0] cs;
    step_n = 0;
    if (it.first_pixel) begin
      spr_mode     = it.mode;
      spr_w        = it.sprite_width;
      spr_h        = it.sprite_height;
      spr_base_col = {7'd0, it.pos_x} + {8'd0, cfg_col_off};
      spr_base_row = {7'd0, it.pos_y} + {8'd0, cfg_row_off};
      spr_col      = '0;
      spr_row      = '0;
      // clip test uses the position before the offset
      spr_dropped  = it.pos_x > cfg_panel_w || it.pos_y > cfg_panel_h ||
                     spr_w == '0 || spr_h == '0 ||
                     spr_w > 10'(MAX_DIM) || spr_h > 10'(MAX_DIM);
      sprites_started++;
      if (spr_dropped) sprites_dropped++;
    end
    // dropped sprite, nothing latched yet, or pixels past the last row
    if (spr_dropped || spr_w == '0 || spr_row >= spr_h) return;

    wi = int'(spr_w);
    hi = int'(spr_h);
    c  = int'(spr_col);
    r  = int'(spr_row);
    if (spr_mode == MODE_OPAQUE) begin
      if (c == 0 && r == 0)
        emit_window(spr_base_col, spr_base_col + wi[15:0] - 16'd1,
                    spr_base_row, spr_base_row + hi[15:0] - 16'd1);
      emit(it.pixel[7:0], DC_DATA);
      emit(it.pixel[15:8], DC_DATA);
    end else begin
      // diamond span of this row; may be negative or reach outside the row
      if (r < hi / 2) begin
        shift = wi / 2 - (2 * r + 2);
        span  = 4 * r + 4;
      end else begin
        shift = 2 * r - hi;
        span  = wi - 2 * shift;
      end
      if (c == 0) begin
        cs = spr_base_col + shift[15:0];
        emit_window(cs, cs + span[15:0] - 16'd1,
                    spr_base_row + r[15:0], spr_base_row + r[15:0]);
      end
      if (c >= shift && c < shift + span) begin
        emit(it.pixel[7:0], DC_DATA);
        emit(it.pixel[15:8], DC_DATA);
      end
    end

    if (c + 1 >= wi) begin
      spr_col = '0;
      spr_row = spr_row + 10'd1;
    end else begin
      spr_col = spr_col + 10'd1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Byte checker and run limit
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_bytes
    panel_byte_t due;
    cycle_count++;
    if (push && full) stall_cycles++;
    if (!rst && pop && !empty) begin
      bytes_seen++;
      if (bytes_due.size() == 0) begin
        n_errors++;
        $display("%0t: byte with nothing expected: out_byte %02h is_data %0b last %0b",
                 $time, out_byte, is_data, last);
      end else begin
        due = bytes_due.pop_front();
        if (out_byte !== due.value) begin
          n_errors++;
          $display("%0t: out_byte expected %02h actual %02h", $time, due.value, out_byte);
        end
        if (is_data !== due.is_data) begin
          n_errors++;
          $display("%0t: is_data expected %0b actual %0b", $time, due.is_data, is_data);
        end
        if (last !== due.last) begin
          n_errors++;
          $display("%0t: last expected %0b actual %0b", $time, due.last, last);
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached, %0d bytes still owed",
               $time, CYCLE_LIMIT, bytes_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Byte sink: random pop stalls, one long hold-off, none in the last phase
  // --------------------------------------------------------------------------
  initial begin : byte_sink
    pop = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (!long_hold_done && items_accepted >= HOLD_AT) begin
        // source keeps pushing meanwhile, so the job queue backs up and full rises
        long_hold_done = 1'b1;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        pop <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel source
  // --------------------------------------------------------------------------
  function automatic void add_row(input logic md, fp, input logic [8:0] x, y,
                                  input logic [9:0] w, h, input logic [15:0] pix,
                                  input int want_n, input logic [0:12][7:0] want,
                                  input logic [0:12] want_dc);
    table_row_t row;
    row.it      = {md, fp, x, y, w, h, pix};
    row.want_n  = want_n;
    row.want    = want;
    row.want_dc = want_dc;
    dir_rows.push_back(row);
  endfunction

  // One pixel transfer. Called at a falling edge, returns at a falling edge.
  // Bytes owed come from the model unless the row types them in.
  task automatic send_pixel(input pixel_item_t it, input int want_n,
                            input logic [0:12][7:0] want, input logic [0:12] want_dc);
    panel_byte_t pb;
    int          n;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    push <= 1'b1;
    {mode, first_pixel, pos_x, pos_y, sprite_width, sprite_height, pixel} <= it;
    do @(posedge clk); while (full);
    items_accepted++;
    format_pixel(it);  // always run so the sprite state moves on
    n = (want_n < 0) ? step_n : want_n;
    for (int k = 0; k < n; k++) begin
      if (want_n < 0) begin
        pb = step_buf[k];
      end else begin
        pb.value   = want[k];
        pb.is_data = want_dc[k];
      end
      pb.last = (k == n - 1);
      bytes_due.push_back(pb);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [8:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_PANEL_WIDTH:   cfg_panel_w = v;
      REG_PANEL_HEIGHT:  cfg_panel_h = v;
      REG_COLUMN_OFFSET: cfg_col_off = v[7:0];
      REG_ROW_OFFSET:    cfg_row_off = v[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drain, let dropped pixels clear the pipeline, then rewrite every register.
  task automatic set_registers(input logic [8:0] pw, ph, co, ro);
    push <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    write_reg(REG_PANEL_WIDTH, pw);
    write_reg(REG_PANEL_HEIGHT, ph);
    write_reg(REG_COLUMN_OFFSET, co);
    write_reg(REG_ROW_OFFSET, ro);
    cfg_write <= 1'b0;
  endtask

  // One random sprite: mostly complete, some cut short, overrun, clipped
  // or with an illegal size. Geometry on later pixels is ignored, so it
  // carries noise.
  task automatic send_sprite();
    pixel_item_t it;
    int          total;
    it.mode        = 1'($urandom_range(0, 1));
    it.first_pixel = 1'b1;
    if ($urandom_range(0, 4) == 0) it.pos_x = 9'($urandom_range(0, 511));
    else                           it.pos_x = 9'($urandom_range(0, cfg_panel_w));
    if ($urandom_range(0, 4) == 0) it.pos_y = 9'($urandom_range(0, 511));
    else                           it.pos_y = 9'($urandom_range(0, cfg_panel_h));
    it.sprite_width  = 10'($urandom_range(1, 10));
    it.sprite_height = 10'($urandom_range(1, 8));
    total = it.sprite_width * it.sprite_height;
    case ($urandom_range(0, 9))
      0: begin
        // illegal size: zero or above the largest side
        if ($urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 2) == 0) it.sprite_width = '0;
          else                           it.sprite_width = 10'($urandom_range(513, 1023));
        end else begin
          if ($urandom_range(0, 2) == 0) it.sprite_height = '0;
          else                           it.sprite_height = 10'($urandom_range(513, 1023));
        end
        total = $urandom_range(1, 3);
      end
      1: begin
        // large sprite, only its first few pixels
        it.sprite_width  = 10'($urandom_range(257, 512));
        it.sprite_height = 10'($urandom_range(257, 512));
        total = $urandom_range(1, 3);
      end
      2: total = $urandom_range(1, total);
      3: total = total + $urandom_range(1, 3);
      default: ;
    endcase
    for (int k = 0; k < total; k++) begin
      if (k > 0) begin
        it.mode          = 1'($urandom_range(0, 1));
        it.first_pixel   = 1'b0;
        it.pos_x         = 9'($urandom_range(0, 511));
        it.pos_y         = 9'($urandom_range(0, 511));
        it.sprite_width  = 10'($urandom_range(0, 1023));
        it.sprite_height = 10'($urandom_range(0, 1023));
      end
      it.pixel = 16'($urandom_range(0, 65535));
      send_pixel(it, -1, '0, '0);
    end
  endtask

  initial begin : pixel_source
    int start;
    rst       = 1'b1;
    push      = 1'b0;
    {mode, first_pixel, pos_x, pos_y, sprite_width, sprite_height, pixel} = '0;
    cfg_write = 1'b0;
    cfg_index = REG_PANEL_WIDTH;
    cfg_data  = '0;

    cfg_panel_w  = PANEL_WIDTH_RST;
    cfg_panel_h  = PANEL_HEIGHT_RST;
    cfg_col_off  = '0;
    cfg_row_off  = '0;
    spr_mode     = MODE_OPAQUE;
    spr_base_col = '0;
    spr_base_row = '0;
    spr_w        = '0;
    spr_h        = '0;
    spr_col      = '0;
    spr_row      = '0;
    spr_dropped  = 1'b0;

    // directed table, reset register values (320 x 240, no offsets)
    // pixel before any sprite: nothing
    add_row(MODE_OPAQUE, 1'b0, 9'd0, 9'd0, 10'd1, 10'd1, 16'h1234, 0, '0, '0);
    // 1x1 opaque at the origin: full window then the pixel, low byte first
    add_row(MODE_OPAQUE, 1'b1, 9'd0, 9'd0, 10'd1, 10'd1, 16'hA55A, 13,
            WIN_ORIGIN_PIX, DC_WIN_PIX);
    // pixel past the end of that sprite, noisy geometry: nothing
    add_row(MODE_ISOMETRIC, 1'b0, 9'd511, 9'd511, 10'd1023, 10'd1023, 16'hFFFF,
            0, '0, '0);
    // clipped: x beyond the panel width, then y beyond the panel height
    add_row(MODE_OPAQUE, 1'b1, 9'd321, 9'd0, 10'd2, 10'd1, 16'h0001, 0, '0, '0);
    add_row(MODE_ISOMETRIC, 1'b1, 9'd0, 9'd241, 10'd2, 10'd2, 16'h0002, 0, '0, '0);
    // illegal sizes: zero width, zero height, above the largest side
    add_row(MODE_OPAQUE, 1'b1, 9'd5, 9'd5, 10'd0, 10'd1, 16'h0003, 0, '0, '0);
    add_row(MODE_OPAQUE, 1'b1, 9'd5, 9'd5, 10'd1, 10'd0, 16'h0004, 0, '0, '0);
    add_row(MODE_OPAQUE, 1'b1, 9'd5, 9'd5, 10'd513, 10'd1, 16'h0005, 0, '0, '0);
    add_row(MODE_ISOMETRIC, 1'b1, 9'd5, 9'd5, 10'd4, 10'd1023, 16'h0006, 0, '0, '0);
    // largest sprite right on the panel corner, then one plain pixel
    add_row(MODE_OPAQUE, 1'b1, 9'd320, 9'd240, 10'd512, 10'd512, 16'hFFFF, 13,
            WIN_CORNER_PIX, DC_WIN_PIX);
    add_row(MODE_ISOMETRIC, 1'b0, 9'd0, 9'd0, 10'd0, 10'd0, 16'h0000, 2,
            PIX_ZERO, DC_PIX);
    // isometric 2x4 at the origin: first span starts left of column 0,
    // last row has an empty span
    add_row(MODE_ISOMETRIC, 1'b1, 9'd0, 9'd0, 10'd2, 10'd4, 16'hC3A1, -1, '0, '0);
    for (int k = 1; k < 8; k++)
      add_row(k[0], 1'b0, 9'd0, 9'd0, 10'd0, 10'd0, 16'h1111 * k[15:0], -1, '0, '0);
    // isometric 1x3: the last row has a negative span, so window only
    add_row(MODE_ISOMETRIC, 1'b1, 9'd100, 9'd200, 10'd1, 10'd3, 16'h8001, -1, '0, '0);
    add_row(MODE_OPAQUE, 1'b0, 9'd0, 9'd0, 10'd0, 10'd0, 16'h7FFE, -1, '0, '0);
    add_row(MODE_ISOMETRIC, 1'b0, 9'd0, 9'd0, 10'd0, 10'd0, 16'h5555, -1, '0, '0);
    // largest isometric sprite, cut short after two pixels
    add_row(MODE_ISOMETRIC, 1'b1, 9'd320, 9'd240, 10'd512, 10'd512, 16'hAAAA, -1,
            '0, '0);
    add_row(MODE_OPAQUE, 1'b0, 9'd0, 9'd0, 10'd0, 10'd0, 16'h0F0F, -1, '0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_pixel(dir_rows[i].it, dir_rows[i].want_n, dir_rows[i].want, dir_rows[i].want_dc);

    // random sprites under four register settings; each change waits for
    // the block to drain, which is also the source's full pause
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_registers(9'd511, 9'd511, 9'd255, 9'd255);
        1: set_registers(9'd0, 9'd0, 9'd0, 9'd0);
        2: set_registers(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                         9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
        default: begin
          set_registers(PANEL_WIDTH_RST, PANEL_HEIGHT_RST, 9'd0, 9'd0);
          no_idle = 1'b1;  // closing stretch at full rate on both sides
        end
      endcase
      start = items_accepted;
      while (items_accepted - start < PHASE_ITEMS) send_sprite();
    end

    push <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d pixel transfers in %0d sprites (%0d dropped), %0d bytes checked",
             items_accepted, sprites_started, sprites_dropped, bytes_seen);
    $display("under reset and four written register settings; input stalled %0d cycles",
             stall_cycles);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
